// ===== rtl/mcfq_pkg.sv =====
// mcfq_pkg: shared constants, types and helpers for the MSDF clash fix block.
// No dependencies.
`default_nettype none

package mcfq_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int DimW      = 9;
  localparam int PtrW      = $clog2(MaxWidth);
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int TotalW    = $clog2(MaxWidth * MaxHeight + 1);
  localparam int PadW      = $clog2(MaxWidth + 3);
  localparam int ThrW      = 15;
  localparam int GainW     = 16;
  localparam int FifoDepth = 8;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int CntW      = FifoAw + 1;

  localparam logic signed [33:0] HalfQ16 = 34'sd8355840;
  localparam logic signed [33:0] TopQ16  = 34'sd16711680;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2,
    REG_GAIN   = 2'd3
  } reg_idx_t;

  typedef logic [63:0] pixel_t;

  typedef struct packed {
    logic            emit;
    logic            last;
    logic [ColW-1:0] cx;
    logic [RowW-1:0] cy;
    logic [PtrW-1:0] ptr;
    pixel_t          px;
  } op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] tru;
    logic       clash;
    logic       last;
  } result_t;

  function automatic logic signed [15:0] chan(pixel_t px, int k);
    chan = px[16*k +: 16];
  endfunction

  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] v, logic [DimW-1:0] lim);
    if (v == '0) eff_dim = DimW'(1);
    else if (v > lim) eff_dim = lim;
    else eff_dim = v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mcfq_ram.sv =====
// mcfq_ram: generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old word. No dependencies.
`default_nettype none

module mcfq_ram #(
  parameter int Width = 128,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mcfq_clash_lane.sv =====
// mcfq_clash_lane: sign clash test of the center pixel against one neighbor.
// Depends on mcfq_pkg.
`default_nettype none

module mcfq_clash_lane (
  input  mcfq_pkg::pixel_t          center,
  input  mcfq_pkg::pixel_t          nbr,
  input  logic [mcfq_pkg::ThrW-1:0] thr,
  input  logic                      en,
  output logic                      hit
);

  always_comb begin
    logic signed [16:0] ca;
    logic signed [16:0] cb;
    logic [16:0] ma;
    logic [16:0] mb;
    logic [2:0] hits;
    hits = '0;
    for (int k = 0; k < 4; k++) begin
      ca = 17'(mcfq_pkg::chan(center, k));
      cb = 17'(mcfq_pkg::chan(nbr, k));
      ma = ca[16] ? 17'(-ca) : 17'(ca);
      mb = cb[16] ? 17'(-cb) : 17'(cb);
      if ((ma >= 17'(thr) || mb >= 17'(thr)) && (ca[16] != cb[16])) begin
        hits = hits + 3'd1;
      end
    end
    hit = en && (hits >= 3'd2);
  end

endmodule

`default_nettype wire

// ===== rtl/mcfq_quant_lane.sv =====
// mcfq_quant_lane: one channel of the quantizer, d*gain registered, then
// offset, clamp and floor. Depends on mcfq_pkg.
`default_nettype none

module mcfq_quant_lane (
  input  logic                       clk,
  input  logic signed [15:0]         dval,
  input  logic [mcfq_pkg::GainW-1:0] gain,
  output logic [7:0]                 level
);

  logic signed [32:0] prod;
  logic signed [33:0] sum;

  always_ff @(posedge clk) begin
    prod <= dval * $signed({1'b0, gain});
  end

  always_comb begin
    sum = {prod[32], prod} + mcfq_pkg::HalfQ16;
    if (sum < 0) level = 8'd0;
    else if (sum >= mcfq_pkg::TopQ16) level = 8'd255;
    else level = sum[23:16];
  end

endmodule

`default_nettype wire

// ===== rtl/msdf_clash_fix_and_quantize_top.sv =====
// msdf_clash_fix_and_quantize_top: line-buffered 3x3 clash fix and byte quantizer.
// Depends on mcfq_pkg, mcfq_ram, mcfq_clash_lane, mcfq_quant_lane.
//
// Pixel words come in on pix_valid/pix_ready in raster order (cmd 0), flush
// words (cmd 1) drain the tail of the frame. Result words leave on
// res_valid/res_ready. A pixel's result becomes due once frame_width+1 later
// pixels are in, or once the whole frame is in; each input word releases at
// most one result. Throughput is one word per clock while pix_ready is high.
// res_valid rises once the releasing word has passed the op register, line
// buffer RAM read, window register, clash/median register, multiply register
// and FIFO write. Frames with width*height below width+2 insert internal
// shift cycles on the last pixel, with pix_ready low.
// Eight clash lanes test the center against each neighbor in parallel; their
// flags are ORed. Four quantizer lanes handle the channels.
// A stalled receiver fills an 8-word output FIFO; pix_ready drops when the
// FIFO plus results in flight reach 8. Reset (rst, synchronous) restores the
// registers to defaults and empties the pipeline; line buffer RAM content is
// not cleared and needs none. Width or height writes restart the frame.
`default_nettype none

module msdf_clash_fix_and_quantize_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               pix_valid,
  output logic               pix_ready,
  input  logic               cmd,
  input  logic signed [15:0] dist_red,
  input  logic signed [15:0] dist_green,
  input  logic signed [15:0] dist_blue,
  input  logic signed [15:0] dist_true,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         byte_red,
  output logic [7:0]         byte_green,
  output logic [7:0]         byte_blue,
  output logic [7:0]         byte_true,
  output logic               had_clash,
  output logic               frame_end
);

  // config registers
  logic [mcfq_pkg::DimW-1:0]   frame_width;
  logic [mcfq_pkg::DimW-1:0]   frame_height;
  logic [mcfq_pkg::ThrW-1:0]   clash_threshold;
  logic [mcfq_pkg::GainW-1:0]  color_gain;
  logic [mcfq_pkg::DimW-1:0]   eff_w;
  logic [mcfq_pkg::DimW-1:0]   eff_h;
  logic [mcfq_pkg::TotalW-1:0] total;

  logic                        cfg_wr;
  mcfq_pkg::reg_idx_t          widx;
  logic [mcfq_pkg::DimW-1:0]   new_eff;
  logic [2*mcfq_pkg::DimW-1:0] total_w_next;
  logic [2*mcfq_pkg::DimW-1:0] total_h_next;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign widx   = mcfq_pkg::reg_idx_t'(paddr[3:2]);
  assign new_eff = mcfq_pkg::eff_dim(pwdata[mcfq_pkg::DimW-1:0],
                     (widx == mcfq_pkg::REG_WIDTH) ? mcfq_pkg::DimW'(mcfq_pkg::MaxWidth)
                                                   : mcfq_pkg::DimW'(mcfq_pkg::MaxHeight));
  assign total_w_next = new_eff * eff_h;
  assign total_h_next = eff_w * new_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= mcfq_pkg::DimW'(32);
      frame_height    <= mcfq_pkg::DimW'(32);
      clash_threshold <= '0;
      color_gain      <= mcfq_pkg::GainW'(256);
      eff_w           <= mcfq_pkg::DimW'(32);
      eff_h           <= mcfq_pkg::DimW'(32);
      total           <= mcfq_pkg::TotalW'(1024);
    end else if (cfg_wr) begin
      unique case (widx)
        mcfq_pkg::REG_WIDTH: begin
          frame_width <= pwdata[mcfq_pkg::DimW-1:0];
          eff_w       <= new_eff;
          total       <= mcfq_pkg::TotalW'(total_w_next);
        end
        mcfq_pkg::REG_HEIGHT: begin
          frame_height <= pwdata[mcfq_pkg::DimW-1:0];
          eff_h        <= new_eff;
          total        <= mcfq_pkg::TotalW'(total_h_next);
        end
        mcfq_pkg::REG_THRESH: clash_threshold <= pwdata[mcfq_pkg::ThrW-1:0];
        mcfq_pkg::REG_GAIN:   color_gain <= pwdata[mcfq_pkg::GainW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      mcfq_pkg::REG_WIDTH:  prdata = 32'(frame_width);
      mcfq_pkg::REG_HEIGHT: prdata = 32'(frame_height);
      mcfq_pkg::REG_THRESH: prdata = 32'(clash_threshold);
      mcfq_pkg::REG_GAIN:   prdata = 32'(color_gain);
    endcase
  end

  logic size_wr;
  assign size_wr = cfg_wr && (widx == mcfq_pkg::REG_WIDTH || widx == mcfq_pkg::REG_HEIGHT);

  localparam int CntW_L = mcfq_pkg::CntW + 1;

  // frame control
  logic [mcfq_pkg::TotalW-1:0] in_pos;
  logic [mcfq_pkg::TotalW-1:0] out_pos;
  logic [mcfq_pkg::ColW-1:0]   ox;
  logic [mcfq_pkg::RowW-1:0]   oy;
  logic [mcfq_pkg::PtrW-1:0]   ptr;
  logic [mcfq_pkg::PadW-1:0]   pad_cnt;
  logic                        pad_last;

  logic                        acc;
  logic                        store;
  logic [mcfq_pkg::TotalW-1:0] in_after;
  logic [mcfq_pkg::TotalW:0]   lag_lim;
  logic                        item_emit;
  logic                        item_last;
  logic                        pad_need;
  logic [mcfq_pkg::TotalW:0]   pad_len;
  logic                        op_valid;
  mcfq_pkg::op_t               op;
  logic [mcfq_pkg::DimW-1:0]   ptr_inc;
  logic [mcfq_pkg::DimW-1:0]   ox_inc;
  logic [CntW_L-1:0]           occ;

  assign acc      = pix_valid && pix_ready;
  assign store    = !cmd && (in_pos < total);
  assign in_after = in_pos + mcfq_pkg::TotalW'(store);
  assign lag_lim  = {1'b0, out_pos} + (mcfq_pkg::TotalW + 1)'(eff_w) + (mcfq_pkg::TotalW + 1)'(2);
  assign item_emit = (out_pos < in_after) &&
                     (in_after >= total || {1'b0, in_after} >= lag_lim);
  assign item_last = (out_pos + mcfq_pkg::TotalW'(1)) == total;
  assign pad_len  = (mcfq_pkg::TotalW + 1)'(eff_w) + (mcfq_pkg::TotalW + 1)'(2)
                    - {1'b0, total};
  assign pad_need = item_emit && (in_after == total) && (out_pos == '0) &&
                    ((mcfq_pkg::TotalW + 1)'(eff_w) + (mcfq_pkg::TotalW + 1)'(2) > {1'b0, total});
  assign ptr_inc  = {1'b0, ptr} + mcfq_pkg::DimW'(1);
  assign ox_inc   = {1'b0, ox} + mcfq_pkg::DimW'(1);
  assign pix_ready = (pad_cnt == '0) && (occ < CntW_L'(mcfq_pkg::FifoDepth));

  always_comb begin
    op = '0;
    op.ptr = ptr;
    if (pad_cnt != '0) begin
      op_valid = 1'b1;
      op.emit  = (pad_cnt == mcfq_pkg::PadW'(1));
      op.last  = pad_last;
    end else begin
      op_valid = acc && (store || item_emit);
      op.emit  = item_emit && !pad_need;
      op.last  = item_last;
      op.cx    = ox;
      op.cy    = oy;
      if (store) begin
        op.px = {dist_true, dist_blue, dist_green, dist_red};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      in_pos   <= '0;
      out_pos  <= '0;
      ox       <= '0;
      oy       <= '0;
      ptr      <= '0;
      pad_cnt  <= '0;
      pad_last <= 1'b0;
    end else begin
      if (op_valid) begin
        ptr <= (ptr_inc == eff_w) ? '0 : ptr_inc[mcfq_pkg::PtrW-1:0];
      end
      if (pad_cnt != '0) begin
        pad_cnt <= pad_cnt - mcfq_pkg::PadW'(1);
      end else if (acc) begin
        if (pad_need) begin
          pad_cnt  <= mcfq_pkg::PadW'(pad_len);
          pad_last <= item_last;
        end
        if (item_emit && item_last) begin
          in_pos  <= '0;
          out_pos <= '0;
          ox      <= '0;
          oy      <= '0;
        end else begin
          in_pos <= in_after;
          if (item_emit) begin
            out_pos <= out_pos + mcfq_pkg::TotalW'(1);
            if (ox_inc == eff_w) begin
              ox <= '0;
              oy <= oy + mcfq_pkg::RowW'(1);
            end else begin
              ox <= ox_inc[mcfq_pkg::ColW-1:0];
            end
          end
        end
      end
    end
  end

  // line buffers: entry holds {pixel one row back, pixel}
  logic          s0_valid;
  mcfq_pkg::op_t s0;
  logic          s1_valid;
  mcfq_pkg::op_t s1;
  logic          byp_hit;
  logic [127:0]  byp_data;
  logic [127:0]  ram_rdata;
  logic [127:0]  lb;
  logic [127:0]  ram_wdata;

  assign lb        = byp_hit ? byp_data : ram_rdata;
  assign ram_wdata = {lb[63:0], s1.px};

  mcfq_ram #(
    .Width (128),
    .Depth (mcfq_pkg::MaxWidth)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1.ptr),
    .wdata (ram_wdata),
    .raddr (s0.ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      s0_valid <= op_valid;
      s1_valid <= s0_valid;
      byp_hit  <= s0_valid && s1_valid && (s0.ptr == s1.ptr);
    end
  end

  always_ff @(posedge clk) begin
    s0       <= op;
    s1       <= s0;
    byp_data <= ram_wdata;
  end

  // 3x3 window, row 0 is the oldest row, column 2 the newest
  mcfq_pkg::pixel_t          win [3][3];
  logic                      s2_emit;
  logic                      s2_last;
  logic [mcfq_pkg::ColW-1:0] s2_cx;
  logic [mcfq_pkg::RowW-1:0] s2_cy;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= lb[127:64];
      win[1][2] <= lb[63:0];
      win[2][2] <= s1.px;
    end
    s2_last <= s1.last;
    s2_cx   <= s1.cx;
    s2_cy   <= s1.cy;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_emit <= 1'b0;
    else s2_emit <= s1_valid && s1.emit;
  end

  // clash lanes
  logic [2:0] row_ok;
  logic [2:0] col_ok;
  logic [8:0] hit_map;
  logic       flag;

  assign row_ok[0] = (s2_cy != '0);
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = (mcfq_pkg::DimW'(s2_cy) + mcfq_pkg::DimW'(1)) < eff_h;
  assign col_ok[0] = (s2_cx != '0);
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = (mcfq_pkg::DimW'(s2_cx) + mcfq_pkg::DimW'(1)) < eff_w;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      if (r == 1 && c == 1) begin : g_ctr
        assign hit_map[r*3+c] = 1'b0;
      end else begin : g_lane
        mcfq_clash_lane u_lane (
          .center (win[1][1]),
          .nbr    (win[r][c]),
          .thr    (clash_threshold),
          .en     (row_ok[r] && col_ok[c]),
          .hit    (hit_map[r*3+c])
        );
      end
    end
  end

  assign flag = |hit_map;

  // median of red, green, blue
  logic signed [15:0] cr, cg, cb, lo, hi, mid, med;

  always_comb begin
    cr  = mcfq_pkg::chan(win[1][1], 0);
    cg  = mcfq_pkg::chan(win[1][1], 1);
    cb  = mcfq_pkg::chan(win[1][1], 2);
    lo  = (cr < cg) ? cr : cg;
    hi  = (cr < cg) ? cg : cr;
    mid = (hi < cb) ? hi : cb;
    med = (lo > mid) ? lo : mid;
  end

  logic               s3_emit;
  logic               s3_last;
  logic               s3_flag;
  logic signed [15:0] s3_red, s3_green, s3_blue, s3_true;

  always_ff @(posedge clk) begin
    s3_last  <= s2_last;
    s3_flag  <= flag;
    s3_red   <= flag ? med : cr;
    s3_green <= flag ? med : cg;
    s3_blue  <= flag ? med : cb;
    s3_true  <= mcfq_pkg::chan(win[1][1], 3);
  end

  // quantizer lanes
  logic       s4_emit;
  logic       s4_last;
  logic       s4_flag;
  logic [7:0] q_red, q_green, q_blue, q_true;

  mcfq_quant_lane u_q_red   (.clk(clk), .dval(s3_red),   .gain(color_gain), .level(q_red));
  mcfq_quant_lane u_q_green (.clk(clk), .dval(s3_green), .gain(color_gain), .level(q_green));
  mcfq_quant_lane u_q_blue  (.clk(clk), .dval(s3_blue),  .gain(color_gain), .level(q_blue));
  mcfq_quant_lane u_q_true  (.clk(clk), .dval(s3_true),  .gain(color_gain), .level(q_true));

  always_ff @(posedge clk) begin
    s4_last <= s3_last;
    s4_flag <= s3_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_emit <= 1'b0;
      s4_emit <= 1'b0;
    end else begin
      s3_emit <= s2_emit;
      s4_emit <= s3_emit;
    end
  end

  // output FIFO
  mcfq_pkg::result_t           fifo_mem [mcfq_pkg::FifoDepth];
  mcfq_pkg::result_t           push_word;
  mcfq_pkg::result_t           head;
  logic [mcfq_pkg::FifoAw-1:0] wr_ptr;
  logic [mcfq_pkg::FifoAw-1:0] rd_ptr;
  logic [mcfq_pkg::CntW-1:0]   fifo_cnt;
  logic                        pop;
  logic [4:0]                  emit_vec;

  assign push_word = '{red: q_red, green: q_green, blue: q_blue, tru: q_true,
                       clash: s4_flag, last: s4_last};
  assign pop       = res_valid && res_ready;
  assign head      = fifo_mem[rd_ptr];
  assign res_valid = (fifo_cnt != '0);
  assign byte_red   = head.red;
  assign byte_green = head.green;
  assign byte_blue  = head.blue;
  assign byte_true  = head.tru;
  assign had_clash  = head.clash;
  assign frame_end  = head.last;

  assign emit_vec = {s0_valid && s0.emit, s1_valid && s1.emit, s2_emit, s3_emit, s4_emit};
  assign occ      = CntW_L'(fifo_cnt) + CntW_L'($countones(emit_vec));

  always_ff @(posedge clk) begin
    if (s4_emit) begin
      fifo_mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (s4_emit) wr_ptr <= wr_ptr + mcfq_pkg::FifoAw'(1);
      if (pop) rd_ptr <= rd_ptr + mcfq_pkg::FifoAw'(1);
      if (s4_emit && !pop) fifo_cnt <= fifo_cnt + mcfq_pkg::CntW'(1);
      else if (pop && !s4_emit) fifo_cnt <= fifo_cnt - mcfq_pkg::CntW'(1);
    end
  end

  // checks
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (s4_emit && !pop) |-> (fifo_cnt < mcfq_pkg::CntW'(mcfq_pkg::FifoDepth)))
    else $error("output fifo overflow");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CntW_L'(mcfq_pkg::FifoDepth))
    else $error("results in flight exceed fifo room");

  a_pad_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (pad_cnt != '0) |-> !pix_ready)
    else $error("input taken during pad shifts");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (acc && pad_cnt == '0 && item_emit && item_last) |=> (in_pos == '0 && out_pos == '0))
    else $error("counters not cleared after frame end");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench: self-checking bench for msdf_clash_fix_and_quantize_top.
// Depends on mcfq_pkg and the block RTL; predicts every result word from an
// internal line-store model and checks the words on the result channel.
`default_nettype none

module testbench;

  localparam int Slots = 2 * mcfq_pkg::MaxWidth + 4;
  localparam int CycleLimit = 600000;

  typedef struct {
    logic [7:0] red, green, blue, tru;
    logic       clash, last;
  } byte_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic pix_valid = 1'b0;
  logic pix_ready;
  logic cmd = 1'b0;
  logic signed [15:0] dist_red = '0, dist_green = '0, dist_blue = '0, dist_true = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [7:0] byte_red, byte_green, byte_blue, byte_true;
  logic had_clash, frame_end;

  msdf_clash_fix_and_quantize_top uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [8:0]  cfg_width = 9'd32, cfg_height = 9'd32;
  logic [14:0] cfg_thresh = '0;
  logic [15:0] cfg_gain = 16'd256;
  logic [63:0] line_store [Slots];
  int unsigned px_in = 0, px_out = 0;
  byte_word_t  pending_bytes [$];

  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_req = 0;
  int cycles = 0, errors = 0, words_sent = 0, words_checked = 0, clash_seen = 0;
  int frames_done = 0;

  function automatic int unsigned eff(logic [8:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int signed lane(logic [63:0] p, int k);
    return int'($signed(p[16*k +: 16]));
  endfunction

  function automatic bit sign_split(logic [63:0] a, logic [63:0] b);
    int hits;
    int ca, cb, ma, mb;
    hits = 0;
    for (int k = 0; k < 4; k++) begin
      ca = lane(a, k);
      cb = lane(b, k);
      ma = ca < 0 ? -ca : ca;
      mb = cb < 0 ? -cb : cb;
      if (ma < int'(cfg_thresh) && mb < int'(cfg_thresh)) continue;
      if ((ca < 0) != (cb < 0)) hits++;
    end
    return hits >= 2;
  endfunction

  function automatic logic [7:0] to_byte(int d);
    longint t;
    t = longint'(d) * longint'(cfg_gain) + 64'sd8355840;
    if (t < 0) return 8'd0;
    if (t >= 64'sd16711680) return 8'd255;
    return 8'(t >>> 16);
  endfunction

  function automatic void predict_word(logic c, logic [63:0] px);
    int unsigned w, h, total, m, x, y;
    int lo, hi, md, r, g, b;
    bit flag;
    logic [63:0] ctr;
    byte_word_t e;
    w = eff(cfg_width, mcfq_pkg::MaxWidth);
    h = eff(cfg_height, mcfq_pkg::MaxHeight);
    total = w * h;
    flag = 0;
    if (!c && px_in < total) begin
      line_store[px_in % Slots] = px;
      px_in++;
    end
    if (!(px_out < px_in && (px_in >= total || px_in >= px_out + w + 2))) return;
    m = px_out;
    x = m % w;
    y = m / w;
    ctr = line_store[m % Slots];
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++) begin
        if (dx == 0 && dy == 0) continue;
        if ((dx < 0 && x == 0) || (dx > 0 && x + 1 >= w)) continue;
        if ((dy < 0 && y == 0) || (dy > 0 && y + 1 >= h)) continue;
        if (sign_split(ctr, line_store[((y + dy) * w + x + dx) % Slots])) flag = 1;
      end
    r = lane(ctr, 0);
    g = lane(ctr, 1);
    b = lane(ctr, 2);
    if (flag) begin
      lo = r < g ? r : g;
      hi = r < g ? g : r;
      md = hi < b ? hi : b;
      md = lo > md ? lo : md;
      r = md; g = md; b = md;
    end
    e.red = to_byte(r);
    e.green = to_byte(g);
    e.blue = to_byte(b);
    e.tru = to_byte(lane(ctr, 3));
    e.clash = flag;
    e.last = (m + 1 == total);
    pending_bytes.push_back(e);
    px_out++;
    if (m + 1 == total) begin
      px_in = 0;
      px_out = 0;
    end
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench failed");
      $finish;
    end
  end

  // result receiver: random stalls plus long hold-offs on request
  int holds_served = 0, hold_left = 0;
  always @(negedge clk) begin
    if (hold_req != holds_served) begin
      holds_served = hold_req;
      hold_left = 400;
    end
    if (rst) res_ready = 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      res_ready = 1'b0;
    end else res_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    byte_word_t e;
    if (!rst && res_valid && res_ready) begin
      words_checked++;
      if (had_clash) clash_seen++;
      if (frame_end) frames_done++;
      if (pending_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        e = pending_bytes.pop_front();
        if (byte_red !== e.red || byte_green !== e.green || byte_blue !== e.blue ||
            byte_true !== e.tru || had_clash !== e.clash || frame_end !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch cycle %0d: exp %h %h %h %h c%b e%b got %h %h %h %h c%b e%b",
                     cycles, e.red, e.green, e.blue, e.tru, e.clash, e.last,
                     byte_red, byte_green, byte_blue, byte_true, had_clash, frame_end);
        end
      end
    end
  end

  task automatic send_word(logic c, logic [63:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_valid = 1'b0;
      @(negedge clk);
    end
    pix_valid = 1'b1;
    cmd = c;
    {dist_true, dist_blue, dist_green, dist_red} = px;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    predict_word(c, px);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    pix_valid = 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic reg_write(mcfq_pkg::reg_idx_t idx, logic [31:0] val);
    drain();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 4'(idx) << 2;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      mcfq_pkg::REG_WIDTH: begin
        cfg_width = val[8:0]; px_in = 0; px_out = 0;
      end
      mcfq_pkg::REG_HEIGHT: begin
        cfg_height = val[8:0]; px_in = 0; px_out = 0;
      end
      mcfq_pkg::REG_THRESH: cfg_thresh = val[14:0];
      mcfq_pkg::REG_GAIN:   cfg_gain = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [15:0] rand_lane(int spread);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(2 * spread) - spread);
  endfunction

  function automatic logic [63:0] rand_pixel();
    return {rand_lane(600), rand_lane(300), rand_lane(300), rand_lane(300)};
  endfunction

  task automatic flush_out();
    while (px_in != 0) send_word(1'b1, '0);
  endtask

  // one frame with noise: early flushes and dropped extra pixels
  task automatic send_frame();
    int unsigned total;
    total = eff(cfg_width, mcfq_pkg::MaxWidth) * eff(cfg_height, mcfq_pkg::MaxHeight);
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(19) == 0) send_word(1'b1, rand_pixel());
      send_word(1'b0, rand_pixel());
    end
    if (px_in != 0 && $urandom_range(3) == 0) send_word(1'b0, rand_pixel());
    flush_out();
  endtask

  task automatic test_directed();
    reg_write(mcfq_pkg::REG_WIDTH, 3);
    reg_write(mcfq_pkg::REG_HEIGHT, 3);
    reg_write(mcfq_pkg::REG_THRESH, 0);
    reg_write(mcfq_pkg::REG_GAIN, 256);
    send_word(1'b1, '0);  // flush before the frame is complete
    send_word(1'b0, 64'h7FFF_8000_0000_FFFF);
    send_word(1'b0, 64'h8000_7FFF_FFFF_0000);
    send_word(1'b0, 64'h0000_0000_0000_0000);
    send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(1'b0, 64'h0100_FF00_0100_FF00);
    send_word(1'b0, 64'h8000_8000_8000_8000);
    send_word(1'b0, 64'h7FFF_7FFF_7FFF_7FFF);
    send_word(1'b0, 64'h5555_AAAA_5555_AAAA);
    send_word(1'b0, 64'hAAAA_5555_AAAA_5555);
    send_word(1'b0, 64'h1234_0000_0000_0000);  // dropped: frame already complete
    flush_out();
    // size write mid-frame restarts the frame
    send_word(1'b0, 64'h0000_FF00_0100_0200);
    send_word(1'b0, 64'h0000_0100_FF00_FE00);
    reg_write(mcfq_pkg::REG_WIDTH, 0);
    reg_write(mcfq_pkg::REG_HEIGHT, 1);
    reg_write(mcfq_pkg::REG_GAIN, 16'hFFFF);
    send_word(1'b0, 64'h0001_FFFF_0000_8000);
    send_word(1'b0, 64'hFFFF_0001_7FFF_0000);
    reg_write(mcfq_pkg::REG_GAIN, 0);
    reg_write(mcfq_pkg::REG_THRESH, 15'h7FFF);
    reg_write(mcfq_pkg::REG_WIDTH, 2);
    reg_write(mcfq_pkg::REG_HEIGHT, 2);
    send_word(1'b0, 64'h8000_7FFF_8000_7FFF);
    send_word(1'b0, 64'h7FFF_8000_7FFF_8000);
    send_word(1'b0, 64'h8000_8000_7FFF_7FFF);
    send_word(1'b0, 64'h0000_0000_0000_0000);
    flush_out();
  endtask

  task automatic test_size_extremes();
    reg_write(mcfq_pkg::REG_THRESH, 40);
    reg_write(mcfq_pkg::REG_GAIN, 256);
    reg_write(mcfq_pkg::REG_WIDTH, 9'h1FF);  // clips to the max width
    reg_write(mcfq_pkg::REG_HEIGHT, 1);
    send_frame();
    reg_write(mcfq_pkg::REG_WIDTH, 1);
    reg_write(mcfq_pkg::REG_HEIGHT, 256);
    send_frame();
  endtask

  task automatic random_settings();
    case ($urandom_range(3))
      0: reg_write(mcfq_pkg::REG_THRESH, 0);
      1: reg_write(mcfq_pkg::REG_THRESH, $urandom_range(400));
      2: reg_write(mcfq_pkg::REG_THRESH, $urandom_range(32767));
      default: ;
    endcase
    case ($urandom_range(4))
      0: reg_write(mcfq_pkg::REG_GAIN, 0);
      1: reg_write(mcfq_pkg::REG_GAIN, 16'hFFFF);
      2: reg_write(mcfq_pkg::REG_GAIN, $urandom_range(65535));
      3: reg_write(mcfq_pkg::REG_GAIN, $urandom_range(128, 1024));
      default: ;
    endcase
    reg_write(mcfq_pkg::REG_WIDTH, $urandom_range(1, 12));
    reg_write(mcfq_pkg::REG_HEIGHT, $urandom_range(1, 10));
  endtask

  task automatic test_random(int sidle, int ridle, int budget);
    int start;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    start = words_sent;
    while (words_sent - start < budget) begin
      random_settings();
      if ($urandom_range(7) == 0) begin
        // abandon a partial frame
        repeat ($urandom_range(1, 6)) send_word(1'b0, rand_pixel());
        reg_write(mcfq_pkg::REG_WIDTH, $urandom_range(1, 12));
      end
      send_frame();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(mcfq_pkg::REG_WIDTH, 16);
    reg_write(mcfq_pkg::REG_HEIGHT, 6);
    hold_req++;
    send_frame();
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) line_store[i] = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_size_extremes();
    test_random(26, 55, 90);
    test_random(55, 26, 90);
    test_random(0, 0, 60);
    test_backpressure();
    drain();
    $display("sent %0d words, checked %0d results over %0d frames, %0d clash fixes",
             words_sent, words_checked, frames_done, clash_seen);
    if (errors == 0 && pending_bytes.size() == 0) $display("testbench passed");
    else begin
      $display("%0d mismatches, %0d results missing", errors, pending_bytes.size());
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/mcfq_pkg.sv
rtl/mcfq_ram.sv
rtl/mcfq_clash_lane.sv
rtl/mcfq_quant_lane.sv
rtl/msdf_clash_fix_and_quantize_top.sv
dv/testbench.sv
